[rtl/core/sqd_pkg.sv]
package sqd_pkg;

  localparam int NUM_QUEUES_DEF  = 4;
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int TICKET_WIDTH    = 16;
  localparam logic [2:0] ACTIVE_RESET = 3'd4;

  typedef enum logic [1:0] {
    ACT_ARRIVE = 2'd0,
    ACT_DEPART = 2'd1,
    ACT_CLOSE  = 2'd2,
    ACT_NONE   = 2'd3
  } act_t;

  typedef enum logic [2:0] {
    KIND_ASSIGNED  = 3'd0,
    KIND_DEPARTED  = 3'd1,
    KIND_NOT_FOUND = 3'd2,
    KIND_REJECTED  = 3'd3,
    KIND_ALL_EMPTY = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ARRIVE,
    S_SCAN,
    S_DRAIN
  } state_t;

  typedef struct packed {
    act_t                    action;
    logic [TICKET_WIDTH-1:0] target_ticket;
  } sqd_in_t;

  typedef struct packed {
    kind_t                   kind;
    logic [TICKET_WIDTH-1:0] ticket;
    logic [1:0]              queue_index;
    logic                    last;
  } sqd_out_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic rot;
  } qctl_t;

endpackage

[rtl/core/sqd_cell.sv]
module sqd_cell #(
  parameter int IDX = 0,
  parameter int LW  = 5
) (
  input  logic                            clk,
  input  sqd_pkg::qctl_t                  ctl,
  input  logic [LW-1:0]                   len,
  input  logic [sqd_pkg::TICKET_WIDTH-1:0] right,
  input  logic [sqd_pkg::TICKET_WIDTH-1:0] front,
  input  logic [sqd_pkg::TICKET_WIDTH-1:0] wdata,
  output logic [sqd_pkg::TICKET_WIDTH-1:0] data_o
);
  import sqd_pkg::*;

  logic [TICKET_WIDTH-1:0] data_r;
  logic [TICKET_WIDTH-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (ctl.push && len == LW'(IDX)) begin
      data_nxt = wdata;
    end else if (ctl.pop) begin
      data_nxt = right;
    end else if (ctl.rot) begin
      data_nxt = (len == LW'(IDX + 1)) ? front : right;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_o = data_r;

endmodule

[rtl/core/sqd_queue.sv]
module sqd_queue #(
  parameter int QUEUE_DEPTH = sqd_pkg::QUEUE_DEPTH_DEF,
  parameter int LW          = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  sqd_pkg::qctl_t                  ctl,
  input  logic [sqd_pkg::TICKET_WIDTH-1:0] wdata,
  output logic [LW-1:0]                   len_o,
  output logic [sqd_pkg::TICKET_WIDTH-1:0] front_o
);
  import sqd_pkg::*;

  logic [LW-1:0]           len_r;
  logic [LW-1:0]           len_nxt;
  logic [TICKET_WIDTH-1:0] cells [QUEUE_DEPTH];

  always_comb begin
    len_nxt = len_r;
    if (ctl.push) begin
      len_nxt = len_r + LW'(1);
    end else if (ctl.pop) begin
      len_nxt = len_r - LW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
    end else begin
      len_r <= len_nxt;
    end
  end

  for (genvar j = 0; j < QUEUE_DEPTH; j++) begin : g_cell
    logic [TICKET_WIDTH-1:0] right;
    if (j == QUEUE_DEPTH - 1) begin : g_end
      assign right = cells[j];
    end else begin : g_mid
      assign right = cells[j+1];
    end
    sqd_cell #(
      .IDX (j),
      .LW  (LW)
    ) u_cell (
      .clk    (clk),
      .ctl    (ctl),
      .len    (len_r),
      .right  (right),
      .front  (cells[0]),
      .wdata  (wdata),
      .data_o (cells[j])
    );
  end

  assign len_o   = len_r;
  assign front_o = cells[0];

endmodule

[rtl/core/shortest_queue_dispatcher.sv]
// Join-the-shortest-queue dispatcher over NUM_QUEUES ticket FIFOs.
// Input channel (in_valid/in_ready/in_data) takes one action per beat:
// arrive, depart by ticket, or close. Unknown actions are dropped silently.
// Result channel (out_valid/out_ready/out_data) carries one beat per result;
// the final beat has last set. Close gives a beat per ticket, or ALL_EMPTY.
// cfg_valid/cfg_ready/cfg_data sets the number of queues taking arrivals;
// write it only while the block is idle. cfg_ready is always high.
// Each queue is a row of cells that shift toward the front.
// Arrive passes through the ARRIVE state to the output register. Depart
// rotates every scanned queue through its cells once, one entry per cycle.
// Close visits the queues in turn and pops the front ticket of each
// non-empty one until every queue is empty.
// One action is in flight at a time; in_ready is high only when idle.
// A finished result waits in the output register; a stalled receiver holds
// the control at its next result step until the beat is taken.
// Reset (rst_n, synchronous) empties all queues, clears the ticket counter
// and sets the active queue count to 4.
module shortest_queue_dispatcher #(
  parameter int NUM_QUEUES  = sqd_pkg::NUM_QUEUES_DEF,
  parameter int QUEUE_DEPTH = sqd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  sqd_pkg::sqd_in_t   in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output sqd_pkg::sqd_out_t  out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_data
);
  import sqd_pkg::*;

  localparam int LW = $clog2(QUEUE_DEPTH + 1);
  localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam logic [3:0] NQ = 4'(NUM_QUEUES);

  state_t                  state_r, state_nxt;
  logic [2:0]              active_r;
  logic [TICKET_WIDTH-1:0] counter_r, counter_nxt;
  logic [TICKET_WIDTH-1:0] tgt_r, tgt_nxt;
  logic [QW-1:0]           q_r, q_nxt;
  logic [LW-1:0]           rem_r, rem_nxt;
  logic                    ld_r, ld_nxt;
  logic                    found_r, found_nxt;
  logic                    out_valid_r, out_valid_nxt;
  sqd_out_t                out_r, out_nxt;

  logic [LW-1:0]           lens   [NUM_QUEUES];
  logic [TICKET_WIDTH-1:0] fronts [NUM_QUEUES];
  qctl_t                   ctl    [NUM_QUEUES];
  logic [NUM_QUEUES-1:0]   nonempty;
  logic [3:0]              n_act;
  logic                    can_emit;

  function automatic logic [1:0] qidx(input logic [QW-1:0] q);
    logic [QW+1:0] x;
    x = {2'b00, q};
    return x[1:0];
  endfunction

  for (genvar i = 0; i < NUM_QUEUES; i++) begin : g_queue
    sqd_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .LW          (LW)
    ) u_queue (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl[i]),
      .wdata   (counter_nxt),
      .len_o   (lens[i]),
      .front_o (fronts[i])
    );
    assign nonempty[i] = (lens[i] != '0);
  end

  always_comb begin
    if (active_r == 3'd0) begin
      n_act = 4'd1;
    end else if ({1'b0, active_r} > NQ) begin
      n_act = NQ;
    end else begin
      n_act = {1'b0, active_r};
    end
  end

  assign can_emit  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    logic [QW-1:0] best;
    logic [LW-1:0] best_len;
    logic          emit;
    logic          adv;
    sqd_out_t      res;

    best = '0;
    best_len = lens[0];
    for (int i = 1; i < NUM_QUEUES; i++) begin
      if (4'(i) < n_act && lens[i] < best_len) begin
        best = QW'(i);
        best_len = lens[i];
      end
    end

    emit        = 1'b0;
    adv         = 1'b0;
    res         = '0;
    state_nxt   = state_r;
    counter_nxt = counter_r;
    tgt_nxt     = tgt_r;
    q_nxt       = q_r;
    rem_nxt     = rem_r;
    ld_nxt      = ld_r;
    found_nxt   = found_r;
    for (int i = 0; i < NUM_QUEUES; i++) begin
      ctl[i] = '0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          tgt_nxt   = in_data.target_ticket;
          q_nxt     = '0;
          ld_nxt    = 1'b1;
          found_nxt = 1'b0;
          case (in_data.action)
            ACT_ARRIVE: state_nxt = S_ARRIVE;
            ACT_DEPART: state_nxt = S_SCAN;
            ACT_CLOSE:  state_nxt = S_DRAIN;
            default:    state_nxt = S_IDLE;
          endcase
        end
      end
      S_ARRIVE: begin
        if (can_emit) begin
          counter_nxt     = counter_r + TICKET_WIDTH'(1);
          emit            = 1'b1;
          res.ticket      = counter_nxt;
          res.queue_index = qidx(best);
          res.last        = 1'b1;
          if (best_len == LW'(QUEUE_DEPTH)) begin
            res.kind = KIND_REJECTED;
          end else begin
            res.kind = KIND_ASSIGNED;
            ctl[best].push = 1'b1;
          end
          state_nxt = S_IDLE;
        end
      end
      S_SCAN: begin
        if (ld_r) begin
          rem_nxt = lens[q_r];
          ld_nxt  = 1'b0;
        end else if (rem_r != '0) begin
          rem_nxt = rem_r - LW'(1);
          if (!found_r && fronts[q_r] == tgt_r) begin
            ctl[q_r].pop = 1'b1;
            found_nxt    = 1'b1;
          end else begin
            ctl[q_r].rot = 1'b1;
          end
        end else if (found_r) begin
          if (can_emit) begin
            emit            = 1'b1;
            res.kind        = KIND_DEPARTED;
            res.ticket      = tgt_r;
            res.queue_index = qidx(q_r);
            res.last        = 1'b1;
            state_nxt       = S_IDLE;
          end
        end else if (q_r == QW'(NUM_QUEUES - 1)) begin
          if (can_emit) begin
            emit       = 1'b1;
            res.kind   = KIND_NOT_FOUND;
            res.ticket = tgt_r;
            res.last   = 1'b1;
            state_nxt  = S_IDLE;
          end
        end else begin
          q_nxt  = q_r + QW'(1);
          ld_nxt = 1'b1;
        end
      end
      S_DRAIN: begin
        if (nonempty == '0) begin
          if (can_emit) begin
            emit      = 1'b1;
            res.kind  = KIND_ALL_EMPTY;
            res.last  = 1'b1;
            state_nxt = S_IDLE;
          end
        end else if (lens[q_r] != '0) begin
          if (can_emit) begin
            emit            = 1'b1;
            res.kind        = KIND_DEPARTED;
            res.ticket      = fronts[q_r];
            res.queue_index = qidx(q_r);
            res.last        = $onehot(nonempty) && (lens[q_r] == LW'(1));
            ctl[q_r].pop    = 1'b1;
            adv             = 1'b1;
            if (res.last) begin
              state_nxt = S_IDLE;
            end
          end
        end else begin
          adv = 1'b1;
        end
        if (adv) begin
          q_nxt = (q_r == QW'(NUM_QUEUES - 1)) ? '0 : q_r + QW'(1);
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_nxt       = res;
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      active_r    <= ACTIVE_RESET;
      counter_r   <= '0;
      q_r         <= '0;
      rem_r       <= '0;
      ld_r        <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      counter_r   <= counter_nxt;
      q_r         <= q_nxt;
      rem_r       <= rem_nxt;
      ld_r        <= ld_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        active_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    tgt_r <= tgt_nxt;
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

[rtl/core/sqd_check.sv]
module sqd_check (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input sqd_pkg::sqd_in_t  in_data,
  input logic              out_valid,
  input logic              out_ready,
  input sqd_pkg::sqd_out_t out_data,
  input logic              cfg_valid,
  input logic              cfg_ready,
  input logic [2:0]        cfg_data
);
  import sqd_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  a_busy_after_action: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.action != ACT_NONE |=> !in_ready)
    else $error("input taken while an action is in flight");

  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind != KIND_DEPARTED |-> out_data.last)
    else $error("single-result beat without last");

  a_empty_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.kind == KIND_ALL_EMPTY || out_data.kind == KIND_NOT_FOUND)
    |-> out_data.queue_index == 2'd0)
    else $error("queue index set on empty or not-found beat");

  a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready |-> in_ready && !out_valid && !$isunknown(cfg_data))
    else $error("configuration beat while an action is in flight");

endmodule

bind shortest_queue_dispatcher sqd_check u_sqd_check (.*);

[test/shortest_queue_dispatcher_checker.sv]
module shortest_queue_dispatcher_checker
  import sqd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_ready,
  input  sqd_in_t  in_data,
  input  logic     out_valid,
  input  logic     out_ready,
  input  sqd_out_t out_data,
  input  logic     cfg_valid,
  input  logic     cfg_ready,
  input  logic [2:0] cfg_data,
  output int       mismatches,
  output int       results_pending
);

  localparam int NQ    = NUM_QUEUES_DEF;
  localparam int DEPTH = QUEUE_DEPTH_DEF;

  logic [TICKET_WIDTH-1:0] lane_tickets [NQ][DEPTH];
  int                      lane_fill [NQ];
  logic [TICKET_WIDTH-1:0] last_ticket;
  logic [2:0]              active_setting;
  sqd_out_t                expected_beats [$];

  function automatic sqd_out_t make_beat(kind_t k, logic [TICKET_WIDTH-1:0] t, int q,
                                         logic l);
    sqd_out_t b;
    b.kind        = k;
    b.ticket      = t;
    b.queue_index = 2'(q);
    b.last        = l;
    return b;
  endfunction

  function automatic void dispatch_action(sqd_in_t item);
    int       n;
    int       best;
    int       drained;
    logic     hit;
    logic     any;
    sqd_out_t tail;
    case (item.action)
      ACT_ARRIVE: begin
        if (active_setting == 3'd0) n = 1;
        else if (int'(active_setting) > NQ) n = NQ;
        else n = int'(active_setting);
        best = 0;
        for (int q = 1; q < n; q++) begin
          if (lane_fill[q] < lane_fill[best]) best = q;
        end
        last_ticket = last_ticket + 1'b1;
        if (lane_fill[best] >= DEPTH) begin
          expected_beats.push_back(make_beat(KIND_REJECTED, last_ticket, best, 1'b1));
        end else begin
          lane_tickets[best][lane_fill[best]] = last_ticket;
          lane_fill[best]++;
          expected_beats.push_back(make_beat(KIND_ASSIGNED, last_ticket, best, 1'b1));
        end
      end
      ACT_DEPART: begin
        hit = 1'b0;
        for (int q = 0; q < NQ && !hit; q++) begin
          for (int j = 0; j < lane_fill[q] && !hit; j++) begin
            if (lane_tickets[q][j] == item.target_ticket) begin
              for (int k = j + 1; k < lane_fill[q]; k++) lane_tickets[q][k-1] = lane_tickets[q][k];
              lane_fill[q]--;
              hit = 1'b1;
              expected_beats.push_back(make_beat(KIND_DEPARTED, item.target_ticket, q, 1'b1));
            end
          end
        end
        if (!hit) begin
          expected_beats.push_back(make_beat(KIND_NOT_FOUND, item.target_ticket, 0, 1'b1));
        end
      end
      ACT_CLOSE: begin
        drained = 0;
        do begin
          any = 1'b0;
          for (int q = 0; q < NQ; q++) begin
            if (lane_fill[q] > 0) begin
              expected_beats.push_back(make_beat(KIND_DEPARTED, lane_tickets[q][0], q, 1'b0));
              for (int k = 1; k < lane_fill[q]; k++) lane_tickets[q][k-1] = lane_tickets[q][k];
              lane_fill[q]--;
              any = 1'b1;
              drained++;
            end
          end
        end while (any);
        if (drained == 0) begin
          expected_beats.push_back(make_beat(KIND_ALL_EMPTY, '0, 0, 1'b1));
        end else begin
          tail = expected_beats.pop_back();
          tail.last = 1'b1;
          expected_beats.push_back(tail);
        end
      end
      default: begin
      end
    endcase
  endfunction

  always @(posedge clk) begin
    sqd_out_t want;
    if (!rst_n) begin
      for (int q = 0; q < NQ; q++) lane_fill[q] = 0;
      last_ticket    = '0;
      active_setting = ACTIVE_RESET;
      expected_beats.delete();
      mismatches     = 0;
    end else begin
      if (cfg_valid && cfg_ready) active_setting = cfg_data;
      if (in_valid && in_ready) dispatch_action(in_data);
      if (out_valid && out_ready) begin
        if (expected_beats.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result beat: expected none, actual kind=%0d ticket=%0d q=%0d last=%0d",
                   $time, out_data.kind, out_data.ticket, out_data.queue_index, out_data.last);
        end else begin
          want = expected_beats.pop_front();
          if (out_data.kind != want.kind) begin
            mismatches++;
            $display("%0t: kind mismatch: expected %0d, actual %0d",
                     $time, want.kind, out_data.kind);
          end
          if (out_data.ticket != want.ticket) begin
            mismatches++;
            $display("%0t: ticket mismatch: expected %0d, actual %0d",
                     $time, want.ticket, out_data.ticket);
          end
          if (out_data.queue_index != want.queue_index) begin
            mismatches++;
            $display("%0t: queue_index mismatch: expected %0d, actual %0d",
                     $time, want.queue_index, out_data.queue_index);
          end
          if (out_data.last != want.last) begin
            mismatches++;
            $display("%0t: last mismatch: expected %0d, actual %0d",
                     $time, want.last, out_data.last);
          end
        end
      end
    end
    results_pending = expected_beats.size();
  end

endmodule

[test/shortest_queue_dispatcher_tb.sv]
module shortest_queue_dispatcher_tb;
  import sqd_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 100;
  localparam int HOLD_CYCLES    = 400;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  sqd_in_t    in_data   = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  sqd_out_t   out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [2:0] cfg_data  = ACTIVE_RESET;

  int mismatches;
  int results_pending;

  int idle_pct  = 0;
  int stall_pct = 0;
  int holds_requested = 0;
  int holds_served    = 0;
  int hold_left       = 0;
  int quiet_cycles    = 0;

  logic [TICKET_WIDTH-1:0] tickets_issued = '0;
  logic [TICKET_WIDTH-1:0] live_tickets [$];

  shortest_queue_dispatcher dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  shortest_queue_dispatcher_checker checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data        (out_data),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .mismatches      (mismatches),
    .results_pending (results_pending)
  );

  always #2 clk = ~clk;

  always @(negedge clk) begin
    if (holds_served != holds_requested) begin
      hold_left = HOLD_CYCLES;
      holds_served++;
    end
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL shortest_queue_dispatcher");
      $finish;
    end
  end

  task automatic send_item(input sqd_in_t item);
    int i;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    case (item.action)
      ACT_ARRIVE: begin
        tickets_issued = tickets_issued + 1'b1;
        live_tickets.push_back(tickets_issued);
      end
      ACT_DEPART: begin
        for (i = 0; i < live_tickets.size(); i++) begin
          if (live_tickets[i] == item.target_ticket) begin
            live_tickets.delete(i);
            break;
          end
        end
      end
      ACT_CLOSE: live_tickets.delete();
      default: begin
      end
    endcase
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (results_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_active(input logic [2:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input logic [2:0] active, input int s_idle, input int r_stall,
                           input int arrive_pct, input int n_items, input logic hold);
    sqd_in_t item;
    int      pick;
    int      counted;
    set_active(active);
    idle_pct  = s_idle;
    stall_pct = r_stall;
    if (hold) holds_requested++;
    counted = 0;
    while (counted < n_items) begin
      item.target_ticket = TICKET_WIDTH'($urandom);
      pick = $urandom_range(99);
      if (pick < arrive_pct) begin
        item.action = ACT_ARRIVE;
      end else begin
        pick = $urandom_range(99);
        if (pick < 55 && live_tickets.size() > 0) begin
          item.action        = ACT_DEPART;
          item.target_ticket = live_tickets[$urandom_range(live_tickets.size() - 1)];
        end else if (pick < 75) begin
          item.action = ACT_DEPART;
        end else if (pick < 90) begin
          item.action = ACT_CLOSE;
        end else begin
          item.action = ACT_NONE;
        end
      end
      send_item(item);
      if (item.action != ACT_NONE) counted++;
    end
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_item('{ACT_CLOSE,  16'h0000});
    send_item('{ACT_DEPART, 16'h0000});
    send_item('{ACT_DEPART, 16'hFFFF});
    send_item('{ACT_NONE,   16'hFFFF});
    repeat (6) send_item('{ACT_ARRIVE, 16'h0000});
    send_item('{ACT_DEPART, 16'd6});
    send_item('{ACT_DEPART, 16'd1});
    send_item('{ACT_DEPART, 16'd3});
    send_item('{ACT_DEPART, 16'd3});
    send_item('{ACT_DEPART, 16'hAAAA});
    send_item('{ACT_CLOSE,  16'hFFFF});
    send_item('{ACT_CLOSE,  16'h5555});
    send_item('{ACT_ARRIVE, 16'hFFFF});
    send_item('{ACT_ARRIVE, 16'h5555});
    send_item('{ACT_DEPART, 16'h5555});
    send_item('{ACT_NONE,   16'h0000});
    send_item('{ACT_CLOSE,  16'h0000});

    run_phase(3'd4, 0,  0,  60, 16, 1'b0);
    run_phase(3'd2, 64, 0,  60, 16, 1'b0);
    run_phase(3'd7, 0,  64, 55, 16, 1'b1);
    run_phase(3'd0, 27, 27, 85, 20, 1'b0);
    run_phase(3'd3, 0,  0,  60, 12, 1'b0);
    run_phase(3'd5, 27, 27, 60, 20, 1'b0);

    drain();
    if (mismatches == 0) $display("PASS shortest_queue_dispatcher");
    else $display("FAIL shortest_queue_dispatcher");
    $finish;
  end

endmodule
